/* rtl/plsb_pkg.sv */
// Shared types and constants for the 2x2 stride-2 pooling line buffer.
package plsb_pkg;

  localparam int FIELDS         = 4;
  localparam int FIELD_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;
  localparam int MODE_BITS      = 2;
  localparam int WIDTH_BITS     = 9;
  localparam int HEIGHT_BITS    = 9;
  localparam int GROUPS_BITS    = 5;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_BYPASS  = 2'd0,
    MODE_MAX     = 2'd1,
    MODE_AVG     = 2'd2,
    MODE_MAX_AVG = 2'd3
  } pool_mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_POOL_MODE      = 2'd0,
    CFG_IMAGE_WIDTH    = 2'd1,
    CFG_IMAGE_HEIGHT   = 2'd2,
    CFG_CHANNEL_GROUPS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic bypass;
    logic average;
  } calc_ctrl_t;

endpackage

/* rtl/pool_2x2_stride2_line_buffer_unit.sv */
// Top level: 2x2 stride-2 max/average pooling or bypass, over a raster stream with alternating row stores.
// Two register stages, stage 1 and the output register, hold each beat on its way to a result.
// Throughput: one input beat per cycle when not stalled; the row stores take one write and all
//   window reads of a beat in the same cycle, and the registered read data feeds the reduction.
// Reset sets configuration to its defaults and restarts position counters; row stores are not cleared.
// A configuration write restarts all position counters; the row stores keep their data.
module pool_2x2_stride2_line_buffer_unit #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_GROUPS  = 16,
  parameter int MAX_HEIGHT  = 256
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [plsb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [plsb_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [plsb_pkg::FIELD_BITS-1:0]  sample_0,
  input  logic signed [plsb_pkg::FIELD_BITS-1:0]  sample_1,
  input  logic signed [plsb_pkg::FIELD_BITS-1:0]  sample_2,
  input  logic signed [plsb_pkg::FIELD_BITS-1:0]  sample_3,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [plsb_pkg::FIELD_BITS-1:0]  result_0,
  output logic signed [plsb_pkg::FIELD_BITS-1:0]  result_1,
  output logic signed [plsb_pkg::FIELD_BITS-1:0]  result_2,
  output logic signed [plsb_pkg::FIELD_BITS-1:0]  result_3
);
  import plsb_pkg::*;

  localparam int DW        = LANES * SAMPLE_BITS;
  localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int GRP_BITS  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WC_BITS   = $clog2(MAX_WIDTH + 2);
  localparam int WGC_BITS  = $clog2(MAX_GROUPS + 2);
  localparam int ADDR_BITS = COL_BITS + GRP_BITS;
  localparam int DEPTH     = MAX_WIDTH * (2 ** GRP_BITS);
  localparam int CW        = ((WC_BITS > WIDTH_BITS) ? WC_BITS : WIDTH_BITS) + 1;
  localparam int GW        = ((WGC_BITS > GROUPS_BITS) ? WGC_BITS : GROUPS_BITS) + 1;
  localparam int HW        = ((ROW_BITS > HEIGHT_BITS) ? ROW_BITS : HEIGHT_BITS) + 1;

  // configuration, stored already clamped
  pool_mode_t               pool_mode;
  logic [WIDTH_BITS-1:0]    img_w;
  logic [HEIGHT_BITS-1:0]   img_h;
  logic [GROUPS_BITS-1:0]   img_g;

  // pooling position counters
  logic [GRP_BITS-1:0]  group_index, group_index_next;
  logic [COL_BITS-1:0]  write_column, write_column_next;
  logic [WC_BITS-1:0]   window_column, window_column_next;
  logic                 row_parity, row_parity_next;
  logic [GRP_BITS-1:0]  st_grp, st_grp_next;
  logic [WC_BITS-1:0]   st_col, st_col_next;
  logic [WGC_BITS-1:0]  wgc, wgc_next;
  // image position counters, advance in every mode
  logic [GRP_BITS-1:0]  it_grp, it_grp_next;
  logic [COL_BITS-1:0]  it_col, it_col_next;
  logic [ROW_BITS-1:0]  it_row, it_row_next;

  logic cfg_write, accept, advance;
  logic pool_on, send, emit;
  logic grp_last, col_last, st_reached, st_grp_last, image_end;
  logic it_grp_last, it_col_last, it_row_last;

  logic [FIELD_BITS-1:0] in_fields [FIELDS];
  logic [FIELD_BITS-1:0] out_fields [FIELDS];
  logic [DW-1:0]         x_word;

  logic [ADDR_BITS-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [WC_BITS-1:0]   wc_minus_one;

  logic [DW-1:0] store_even [DEPTH];
  logic [DW-1:0] store_odd [DEPTH];
  logic [DW-1:0] rd_e0, rd_e1, rd_o0;

  logic          s1_valid;
  calc_ctrl_t    s1_ctrl;
  logic [DW-1:0] s1_x;
  logic          s1_fwd0, s1_fwd1, s1_fwd2;
  logic [DW-1:0] win_tl, win_tr, win_bl, calc_out;
  logic [DW-1:0] out_word;

  logic [CW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic [GW-1:0] g_clamp;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign accept    = in_valid && !in_stall;

  assign in_fields[0] = sample_0;
  assign in_fields[1] = sample_1;
  assign in_fields[2] = sample_2;
  assign in_fields[3] = sample_3;

  always_comb begin
    x_word = '0;
    for (int l = 0; l < LANES; l++) begin
      x_word[l*SAMPLE_BITS +: SAMPLE_BITS] = in_fields[l][SAMPLE_BITS-1:0];
    end
  end

  // clamp of incoming configuration values
  always_comb begin
    w_clamp = CW'(cfg_data);
    if (w_clamp > CW'(MAX_WIDTH)) w_clamp = CW'(MAX_WIDTH);
    w_clamp[0] = 1'b0;
    if (w_clamp < CW'(2)) w_clamp = CW'(2);
    h_clamp = HW'(cfg_data);
    if (h_clamp < HW'(1)) h_clamp = HW'(1);
    if (h_clamp > HW'(MAX_HEIGHT)) h_clamp = HW'(MAX_HEIGHT);
    g_clamp = GW'(cfg_data[GROUPS_BITS-1:0]);
    if (g_clamp < GW'(1)) g_clamp = GW'(1);
    if (g_clamp > GW'(MAX_GROUPS)) g_clamp = GW'(MAX_GROUPS);
  end

  // position counters
  always_comb begin
    pool_on     = (pool_mode != MODE_BYPASS);
    grp_last    = (GW'(group_index) + GW'(1)) == GW'(img_g);
    col_last    = (CW'(write_column) + CW'(1)) == CW'(img_w);
    st_grp_last = (GW'(st_grp) + GW'(1)) == GW'(img_g);
    st_reached  = CW'(st_col) == (CW'(img_w) + CW'(1));
    send        = pool_on && st_reached && (GW'(wgc) >= GW'(img_g));
    emit        = !pool_on || send;
    it_grp_last = (GW'(it_grp) + GW'(1)) == GW'(img_g);
    it_col_last = (CW'(it_col) + CW'(1)) == CW'(img_w);
    it_row_last = (HW'(it_row) + HW'(1)) == HW'(img_h);
    image_end   = it_grp_last && it_col_last && it_row_last;

    group_index_next   = group_index;
    write_column_next  = write_column;
    window_column_next = window_column;
    row_parity_next    = row_parity;
    st_grp_next        = st_grp;
    st_col_next        = st_col;
    wgc_next           = wgc;

    if (pool_on) begin
      if (!st_reached) begin
        if (st_grp_last) begin
          st_grp_next = '0;
          st_col_next = st_col + WC_BITS'(1);
        end else begin
          st_grp_next = st_grp + GRP_BITS'(1);
        end
      end
      if (GW'(wgc) <= GW'(img_g)) wgc_next = wgc + WGC_BITS'(1);
      if (send && grp_last) begin
        wgc_next           = '0;
        window_column_next = window_column + WC_BITS'(2);
        if ((CW'(window_column) + CW'(2)) > CW'(img_w)) begin
          window_column_next = WC_BITS'(1);
          st_grp_next        = '0;
          st_col_next        = '0;
        end
      end
      if (grp_last) begin
        group_index_next = '0;
        if (col_last) begin
          write_column_next = '0;
          row_parity_next   = !row_parity;
        end else begin
          write_column_next = write_column + COL_BITS'(1);
        end
      end else begin
        group_index_next = group_index + GRP_BITS'(1);
      end
    end

    it_grp_next = it_grp;
    it_col_next = it_col;
    it_row_next = it_row;
    if (it_grp_last) begin
      it_grp_next = '0;
      if (it_col_last) begin
        it_col_next = '0;
        it_row_next = it_row + ROW_BITS'(1);
      end else begin
        it_col_next = it_col + COL_BITS'(1);
      end
    end else begin
      it_grp_next = it_grp + GRP_BITS'(1);
    end

    if (image_end) begin
      group_index_next   = '0;
      write_column_next  = '0;
      window_column_next = WC_BITS'(1);
      row_parity_next    = 1'b0;
      st_grp_next        = '0;
      st_col_next        = '0;
      wgc_next           = '0;
      it_grp_next        = '0;
      it_col_next        = '0;
      it_row_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode     <= MODE_BYPASS;
      img_w         <= WIDTH_BITS'(2);
      img_h         <= HEIGHT_BITS'(2);
      img_g         <= GROUPS_BITS'(1);
      group_index   <= '0;
      write_column  <= '0;
      window_column <= WC_BITS'(1);
      row_parity    <= 1'b0;
      st_grp        <= '0;
      st_col        <= '0;
      wgc           <= '0;
      it_grp        <= '0;
      it_col        <= '0;
      it_row        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_POOL_MODE:      pool_mode <= pool_mode_t'(cfg_data[MODE_BITS-1:0]);
        CFG_IMAGE_WIDTH:    img_w     <= w_clamp[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT:   img_h     <= h_clamp[HEIGHT_BITS-1:0];
        CFG_CHANNEL_GROUPS: img_g     <= g_clamp[GROUPS_BITS-1:0];
      endcase
      group_index   <= '0;
      write_column  <= '0;
      window_column <= WC_BITS'(1);
      row_parity    <= 1'b0;
      st_grp        <= '0;
      st_col        <= '0;
      wgc           <= '0;
      it_grp        <= '0;
      it_col        <= '0;
      it_row        <= '0;
    end else if (accept) begin
      group_index   <= group_index_next;
      write_column  <= write_column_next;
      window_column <= window_column_next;
      row_parity    <= row_parity_next;
      st_grp        <= st_grp_next;
      st_col        <= st_col_next;
      wgc           <= wgc_next;
      it_grp        <= it_grp_next;
      it_col        <= it_col_next;
      it_row        <= it_row_next;
    end
  end

  // row stores: write the current beat, read the window neighbors
  assign wc_minus_one = window_column - WC_BITS'(1);
  assign wr_addr      = {write_column, group_index};
  assign rd_addr_a    = {wc_minus_one[COL_BITS-1:0], group_index};
  assign rd_addr_b    = {window_column[COL_BITS-1:0], group_index};

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pool_on && !row_parity) store_even[wr_addr] <= x_word;
      rd_e0 <= store_even[rd_addr_a];
      rd_e1 <= store_even[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pool_on && row_parity) store_odd[wr_addr] <= x_word;
      rd_o0 <= store_odd[rd_addr_a];
    end
  end

  // stage 1: read data back, forward the same-cycle write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl.bypass  <= !pool_on;
      s1_ctrl.average <= (pool_mode == MODE_AVG);
      s1_x            <= x_word;
      s1_fwd0         <= pool_on && !row_parity && (rd_addr_a == wr_addr);
      s1_fwd1         <= pool_on && !row_parity && (rd_addr_b == wr_addr);
      s1_fwd2         <= pool_on && row_parity && (rd_addr_a == wr_addr);
    end
  end

  assign win_tl = s1_fwd0 ? s1_x : rd_e0;
  assign win_tr = s1_fwd1 ? s1_x : rd_e1;
  assign win_bl = s1_fwd2 ? s1_x : rd_o0;

  plsb_window_calc #(
    .LANES       (LANES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_calc (
    .ctrl         (s1_ctrl),
    .top_left     (win_tl),
    .top_right    (win_tr),
    .bottom_left  (win_bl),
    .bottom_right (s1_x),
    .result       (calc_out)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_word <= calc_out;
    end
  end

  for (genvar i = 0; i < FIELDS; i++) begin : g_out
    if (i < LANES) begin : g_lane
      assign out_fields[i] = FIELD_BITS'(out_word[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end else begin : g_zero
      assign out_fields[i] = '0;
    end
  end

  assign result_0 = out_fields[0];
  assign result_1 = out_fields[1];
  assign result_2 = out_fields[2];
  assign result_3 = out_fields[3];

endmodule

/* rtl/plsb_window_calc.sv */
// Per-lane max or floored average over one 2x2 window, or bypass of the current word.
module plsb_window_calc #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  plsb_pkg::calc_ctrl_t           ctrl,
  input  logic [LANES*SAMPLE_BITS-1:0]   top_left,
  input  logic [LANES*SAMPLE_BITS-1:0]   top_right,
  input  logic [LANES*SAMPLE_BITS-1:0]   bottom_left,
  input  logic [LANES*SAMPLE_BITS-1:0]   bottom_right,
  output logic [LANES*SAMPLE_BITS-1:0]   result
);
  import plsb_pkg::*;

  always_comb begin
    logic signed [SAMPLE_BITS-1:0] a, b, c, d, m;
    logic signed [SAMPLE_BITS+1:0] s;
    logic signed [SAMPLE_BITS+1:0] q;
    result = '0;
    for (int l = 0; l < LANES; l++) begin
      a = top_left[l*SAMPLE_BITS +: SAMPLE_BITS];
      b = top_right[l*SAMPLE_BITS +: SAMPLE_BITS];
      c = bottom_left[l*SAMPLE_BITS +: SAMPLE_BITS];
      d = bottom_right[l*SAMPLE_BITS +: SAMPLE_BITS];
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      if (d > m) m = d;
      s = (SAMPLE_BITS+2)'(a) + (SAMPLE_BITS+2)'(b) + (SAMPLE_BITS+2)'(c)
        + (SAMPLE_BITS+2)'(d);
      q = s >>> 2;
      if (ctrl.bypass) begin
        result[l*SAMPLE_BITS +: SAMPLE_BITS] = d;
      end else if (ctrl.average) begin
        result[l*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
      end else begin
        result[l*SAMPLE_BITS +: SAMPLE_BITS] = m;
      end
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the 2x2 stride-2 pooling line buffer: random and directed beats.
`timescale 1ns / 100ps

module tb_top;
  import plsb_pkg::*;

  localparam int MAX_W      = 256;
  localparam int MAX_G      = 16;
  localparam int MAX_H      = 256;
  localparam int STALL_LIMIT = 4000;

  typedef logic [FIELDS-1:0][FIELD_BITS-1:0] lanes_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_POOL_MODE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FIELD_BITS-1:0] sample_0 = '0;
  logic signed [FIELD_BITS-1:0] sample_1 = '0;
  logic signed [FIELD_BITS-1:0] sample_2 = '0;
  logic signed [FIELD_BITS-1:0] sample_3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [FIELD_BITS-1:0] result_0;
  logic signed [FIELD_BITS-1:0] result_1;
  logic signed [FIELD_BITS-1:0] result_2;
  logic signed [FIELD_BITS-1:0] result_3;

  pool_2x2_stride2_line_buffer_unit #(
    .LANES(FIELDS),
    .SAMPLE_BITS(FIELD_BITS),
    .MAX_WIDTH(MAX_W),
    .MAX_GROUPS(MAX_G),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_0(sample_0),
    .sample_1(sample_1),
    .sample_2(sample_2),
    .sample_3(sample_3),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_0(result_0),
    .result_1(result_1),
    .result_2(result_2),
    .result_3(result_3)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pooling model state
  pool_mode_t mode_reg;
  logic [WIDTH_BITS-1:0] width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  logic [GROUPS_BITS-1:0] groups_reg;
  int grp_pos, col_wr, col_win, warmup, win_fill, img_words;
  bit row_odd;
  lanes_t row_buf_even [MAX_W*MAX_G];
  lanes_t row_buf_odd [MAX_W*MAX_G];

  lanes_t pixel_words_todo[$];
  lanes_t pooled_due[$];
  lanes_t drive_word;
  int words_queued = 0;
  int words_taken = 0;
  int results_seen = 0;
  int settings_used = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stuck_cycles = 0;

  function automatic int active_width();
    int w;
    w = width_reg;
    if (w > MAX_W) w = MAX_W;
    w = w & ~1;
    if (w < 2) w = 2;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic int active_groups();
    int g;
    g = groups_reg;
    if (g < 1) g = 1;
    if (g > MAX_G) g = MAX_G;
    return g;
  endfunction

  function automatic int row_slot(int col, int grp);
    if (col >= MAX_W) col = MAX_W - 1;
    if (grp >= MAX_G) grp = MAX_G - 1;
    return col * MAX_G + grp;
  endfunction

  function automatic void restart_positions();
    grp_pos = 0;
    col_wr = 0;
    col_win = 1;
    row_odd = 1'b0;
    warmup = 0;
    win_fill = 0;
    img_words = 0;
  endfunction

  task automatic predict_pool(input lanes_t px, output bit emit, output lanes_t pooled);
    int w, h, g, thr, grp, mx, sum, i, k;
    int v [4];
    lanes_t top_l, top_r, bot_l;
    w = active_width();
    h = active_height();
    g = active_groups();
    emit = 1'b0;
    pooled = '0;
    if (mode_reg == MODE_BYPASS) begin
      pooled = px;
      emit = 1'b1;
    end else begin
      grp = grp_pos;
      thr = w * g + g;
      if (row_odd) row_buf_odd[row_slot(col_wr, grp)] = px;
      else row_buf_even[row_slot(col_wr, grp)] = px;
      if (warmup <= thr) warmup++;
      if (win_fill <= g) win_fill++;
      emit = (warmup > thr) && (win_fill > g);
      if (emit) begin
        top_l = row_buf_even[row_slot(col_win - 1, grp)];
        top_r = row_buf_even[row_slot(col_win, grp)];
        bot_l = row_buf_odd[row_slot(col_win - 1, grp)];
        for (i = 0; i < FIELDS; i++) begin
          v[0] = $signed(top_l[i]);
          v[1] = $signed(top_r[i]);
          v[2] = $signed(bot_l[i]);
          v[3] = $signed(px[i]);
          mx = v[0];
          sum = 0;
          for (k = 0; k < 4; k++) begin
            if (v[k] > mx) mx = v[k];
            sum += v[k];
          end
          pooled[i] = (mode_reg == MODE_AVG) ? FIELD_BITS'(sum >>> 2) : FIELD_BITS'(mx);
        end
      end
      grp_pos++;
      if (emit && grp_pos >= g) begin
        win_fill = 0;
        col_win += 2;
        if (col_win > w) begin
          col_win = 1;
          warmup = 0;
        end
      end
      if (grp_pos >= g) begin
        grp_pos = 0;
        col_wr++;
        if (col_wr >= w) begin
          col_wr = 0;
          row_odd = ~row_odd;
        end
      end
    end
    img_words++;
    if (img_words >= w * h * g) restart_positions();
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_words_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_word = pixel_words_todo.pop_front();
        in_valid <= 1'b1;
        sample_0 <= drive_word[0];
        sample_1 <= drive_word[1];
        sample_2 <= drive_word[2];
        sample_3 <= drive_word[3];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor: tracks config, predicts on each input beat, checks each result beat
  always @(posedge clk) begin : monitor
    lanes_t got, want, pooled;
    bit emit;
    int i;
    if (rst) begin
      mode_reg = MODE_BYPASS;
      width_reg = 2;
      height_reg = 2;
      groups_reg = 1;
      restart_positions();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_POOL_MODE:      mode_reg = pool_mode_t'(cfg_data[MODE_BITS-1:0]);
          CFG_IMAGE_WIDTH:    width_reg = cfg_data[WIDTH_BITS-1:0];
          CFG_IMAGE_HEIGHT:   height_reg = cfg_data[HEIGHT_BITS-1:0];
          CFG_CHANNEL_GROUPS: groups_reg = cfg_data[GROUPS_BITS-1:0];
          default: ;
        endcase
        restart_positions();
      end
      if (in_valid && !in_stall) begin
        predict_pool({sample_3, sample_2, sample_1, sample_0}, emit, pooled);
        words_taken++;
        if (emit) pooled_due.push_back(pooled);
      end
      if (out_valid && !out_stall) begin
        got = {result_3, result_2, result_1, result_0};
        results_seen++;
        if (pooled_due.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          mismatches++;
        end else begin
          want = pooled_due.pop_front();
          for (i = 0; i < FIELDS; i++) begin
            if (got[i] !== want[i]) begin
              $error("result_%0d: expected %0d, actual %0d", i,
                     $signed(want[i]), $signed(got[i]));
              mismatches++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic lanes_t pack4(int a, int b, int c, int d);
    return {FIELD_BITS'(d), FIELD_BITS'(c), FIELD_BITS'(b), FIELD_BITS'(a)};
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_word(input lanes_t px);
    pixel_words_todo.push_back(px);
    words_queued++;
  endtask

  task automatic queue_random(input int n);
    int i;
    for (i = 0; i < n; i++)
      queue_word({rand_sample(), rand_sample(), rand_sample(), rand_sample()});
  endtask

  // drain everything, then give the pipeline time to go quiet
  task automatic settle();
    while (words_taken != words_queued || pooled_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input pool_mode_t m, input int w, input int h, input int g);
    settle();
    write_reg(CFG_POOL_MODE, {7'($urandom), m});
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(CFG_CHANNEL_GROUPS, CFG_DATA_BITS'(g));
    settings_used++;
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin : stim
    int ph, w, h, g;
    pool_mode_t m;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bypass at reset defaults
    queue_word(pack4(32767, 32767, 32767, 32767));
    queue_word(pack4(-32768, -32768, -32768, -32768));
    queue_word(pack4(0, -1, 32767, -32768));

    // each window position wins one lane
    set_geometry(MODE_MAX, 2, 2, 1);
    queue_word(pack4(32767, -32768, -32768, -32768));
    queue_word(pack4(-32768, 32767, -1, 0));
    queue_word(pack4(0, -32768, 32767, -32768));
    queue_word(pack4(-1, -2, -3, 32767));

    // average rounds toward minus infinity
    set_geometry(MODE_AVG, 2, 2, 1);
    queue_word(pack4(-1, -32768, 32767, 1));
    queue_word(pack4(-1, -32768, 32767, 1));
    queue_word(pack4(-1, -32768, 32767, 1));
    queue_word(pack4(0, -32768, 32767, 0));

    // both mode bits set: max
    set_geometry(MODE_MAX_AVG, 2, 2, 1);
    queue_word(pack4(5, -7, 100, -100));
    queue_word(pack4(-5, 7, -100, -99));
    queue_word(pack4(4, 6, 99, -101));
    queue_word(pack4(-4, -8, 101, -102));

    // odd width rounds down, zero groups clamps, odd height leaves a row unpooled
    set_geometry(MODE_MAX, 3, 3, 0);
    queue_random(6);

    for (ph = 0; ph < 12; ph++) begin
      m = pool_mode_t'($urandom_range(0, 3));
      g = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 4);
      if (g > 4) w = $urandom_range(0, 3);
      else if ($urandom_range(0, 4) == 0) w = $urandom_range(0, 9);
      else w = 2 * $urandom_range(1, 5);
      if ($urandom_range(0, 5) == 0) h = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
      else h = $urandom_range(1, 5);
      set_geometry(m, w, h, g);
      set_idling(ph % 4);
      queue_random(12);
    end

    // most groups, then the widest row
    set_geometry(MODE_AVG, 2, 2, 31);
    set_idling(2);
    queue_random(64);
    set_geometry(MODE_MAX, 511, 511, 1);
    set_idling(3);
    queue_random(280);

    while (words_taken != words_queued || pooled_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d input beats and %0d result beats over %0d register settings,",
             words_taken, results_seen, settings_used);
    $display("with bypass, max and average pooling under sender gaps and receiver stalls.");
    if (mismatches == 0 && pooled_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
